>>> hdl/srv_pkg.sv
// Shared types and constants for the three-channel servo PWM block.
// No dependencies; every other file of the block but srv_chk refers to it by scoped names.
package srv_pkg;

    // Channel count and PWM counter geometry
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned PWM_BITS = 10;
    localparam logic [PWM_BITS-1:0] PWM_TOP = '1;

    // Default ramp step delays in milliseconds
    localparam int unsigned STEP_MS_CH1 = 150;
    localparam int unsigned STEP_MS_CH2 = 150;
    localparam int unsigned STEP_MS_CH3 = 1;

    // Reset position of every channel, midway between the reset limits
    localparam logic [7:0] RESET_POS = 8'd79;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_PULSE_MIN    = 8'd35;
    localparam logic [7:0]  RST_PULSE_MAX    = 8'd123;
    localparam logic [15:0] RST_TICKS_PER_MS = 16'd58;

    // Command codes
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_FREE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CH1_MIN = 3'd0;
    localparam logic [2:0] CFG_CH1_MAX = 3'd1;
    localparam logic [2:0] CFG_CH2_MIN = 3'd2;
    localparam logic [2:0] CFG_CH2_MAX = 3'd3;
    localparam logic [2:0] CFG_CH3_MIN = 3'd4;
    localparam logic [2:0] CFG_CH3_MAX = 3'd5;
    localparam logic [2:0] CFG_TICKS   = 3'd6;

    // Angle range and divide-by-180 through a reciprocal:
    // floor(p / 180) == (p * 46604) >> 23 for every p up to 255 * 180
    localparam logic [7:0]  MAX_DEG     = 8'd180;
    localparam logic [31:0] RECIP_180   = 32'd46604;
    localparam int unsigned RECIP_SHIFT = 23;

    // Word held in the input register
    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  ch;
        logic [7:0]  mn;     // pulse minimum of the addressed channel
        logic        inv;    // maximum below minimum
        logic [15:0] prod;   // (max - min) * clamped degree
    } t_item;

    // Per-channel control for one processed word
    typedef struct packed {
        logic       set;
        logic       free;
        logic       wrap;
        logic       ms_tick;
        logic [7:0] tgt;
    } t_ch_ctl;

endpackage

>>> hdl/srv_in_stage.sv
// Input register of the servo block: captures one word and forms the angle product.
// Depends on srv_pkg for the item type, channel count and angle limit.
module srv_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [1:0]           i_channel,
    input  logic [7:0]           i_degree,
    input  logic [7:0]           i_pulse_min [srv_pkg::NUM_CH],
    input  logic [7:0]           i_pulse_max [srv_pkg::NUM_CH],
    input  logic                 i_take,
    output logic                 o_vld,
    output srv_pkg::t_item       o_item
);

    logic           r_vld;
    srv_pkg::t_item r_item;
    srv_pkg::t_item n_item;
    logic [7:0]     sel_min;
    logic [7:0]     sel_max;
    logic [7:0]     deg_sat;
    logic [7:0]     diff;
    logic           accept;

    // Pick the limits of the addressed channel; code 3 names none and gets the first channel's
    always_comb begin
        sel_min = i_pulse_min[0];
        sel_max = i_pulse_max[0];
        case (i_channel)
            2'd1: begin
                sel_min = i_pulse_min[1];
                sel_max = i_pulse_max[1];
            end
            2'd2: begin
                sel_min = i_pulse_min[2];
                sel_max = i_pulse_max[2];
            end
            default: begin
                sel_min = i_pulse_min[0];
                sel_max = i_pulse_max[0];
            end
        endcase
    end

    // Saturate the angle and form the span product
    always_comb begin
        deg_sat     = (i_degree > srv_pkg::MAX_DEG) ? srv_pkg::MAX_DEG : i_degree;
        diff        = sel_max - sel_min;
        n_item.cmd  = i_command;
        n_item.ch   = i_channel;
        n_item.mn   = sel_min;
        n_item.inv  = (sel_max < sel_min);
        n_item.prod = 16'(diff) * 16'(deg_sat);
    end

    assign o_in_stall = r_vld && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    // Hold the word until the result side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

>>> hdl/srv_ramp_ch.sv
// One servo channel: compare value, double-buffered active compare and slew ramp.
// Depends on srv_pkg for the control struct, reset position and PWM width.
module srv_ramp_ch #(
    parameter int unsigned STEP_MS = srv_pkg::STEP_MS_CH1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srv_pkg::t_ch_ctl             i_ctl,
    output logic [srv_pkg::PWM_BITS-1:0] o_cmp_next,
    output logic [srv_pkg::PWM_BITS-1:0] o_act_cmp_next,
    output logic                         o_moving_next
);

    localparam logic [7:0] STEP_LOW = STEP_MS[7:0];
    localparam logic [7:0] DELAY    = (STEP_LOW == 8'd0) ? 8'd1 : STEP_LOW;

    logic [srv_pkg::PWM_BITS-1:0] r_cmp;
    logic [srv_pkg::PWM_BITS-1:0] r_act_cmp;
    logic [7:0]                   r_tgt;
    logic [7:0]                   r_wait;
    logic                         r_moving;

    logic [srv_pkg::PWM_BITS-1:0] n_cmp;
    logic [srv_pkg::PWM_BITS-1:0] n_act_cmp;
    logic [7:0]                   n_tgt;
    logic [7:0]                   n_wait;
    logic                         n_moving;

    logic       do_step;
    logic [7:0] step_tgt;
    logic [7:0] cur;
    logic [7:0] nxt;

    // Step toward the target on a set, or when the wait has run out
    always_comb begin
        do_step  = i_ctl.set || (i_ctl.ms_tick && r_moving && (r_wait <= 8'd1));
        step_tgt = i_ctl.set ? i_ctl.tgt : r_tgt;
        cur      = r_cmp[7:0];
        if (cur < step_tgt) begin
            nxt = cur + 8'd1;
        end else if (cur > step_tgt) begin
            nxt = cur - 8'd1;
        end else begin
            nxt = cur;
        end
    end

    // Next channel state
    always_comb begin
        n_cmp     = r_cmp;
        n_act_cmp = i_ctl.wrap ? r_cmp : r_act_cmp;
        n_tgt     = i_ctl.set ? i_ctl.tgt : r_tgt;
        n_wait    = r_wait;
        n_moving  = r_moving;
        if (i_ctl.free) begin
            n_cmp    = srv_pkg::PWM_TOP;
            n_wait   = 8'd0;
            n_moving = 1'b0;
        end else if (do_step) begin
            n_cmp    = srv_pkg::PWM_BITS'(nxt);
            n_moving = (nxt != step_tgt);
            n_wait   = (nxt != step_tgt) ? DELAY : 8'd0;
        end else if (i_ctl.ms_tick && r_moving) begin
            n_wait = r_wait - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp     <= srv_pkg::PWM_BITS'(srv_pkg::RESET_POS);
            r_act_cmp <= srv_pkg::PWM_BITS'(srv_pkg::RESET_POS);
            r_tgt     <= srv_pkg::RESET_POS;
            r_wait    <= 8'd0;
            r_moving  <= 1'b0;
        end else begin
            r_cmp     <= n_cmp;
            r_act_cmp <= n_act_cmp;
            r_tgt     <= n_tgt;
            r_wait    <= n_wait;
            r_moving  <= n_moving;
        end
    end

    assign o_cmp_next     = n_cmp;
    assign o_act_cmp_next = n_act_cmp;
    assign o_moving_next  = n_moving;

endmodule

>>> hdl/servo_pwm_slew_ramp.sv
// Top level of the three-channel servo PWM generator with slew-limited ramps.
// Depends on srv_pkg, srv_in_stage and srv_ramp_ch.
//
//   channel  | direction | handshake                  | contents
//   ---------+-----------+----------------------------+--------------------------------
//   in       | to block  | i_in_valid / o_in_stall    | command, channel, degree
//   out      | from block| o_out_valid / i_out_stall  | pwm levels, moving mask, positions
//   cfg      | to block  | i_cfg_wr_en (no wait)      | index, data
//
// One word per cycle sustained unless the output stalls. The accepting edge registers
// the word and the span-times-angle product; with the result register free or being
// drained, the product is scaled by 1/180, counter, prescaler and channels are updated
// and the result register is loaded. Reset is synchronous and active low; no clearing
// pass. A stalled result holds its register; the input register holds one more word.
module servo_pwm_slew_ramp #(
    parameter int unsigned STEP_MS_CH1 = srv_pkg::STEP_MS_CH1,
    parameter int unsigned STEP_MS_CH2 = srv_pkg::STEP_MS_CH2,
    parameter int unsigned STEP_MS_CH3 = srv_pkg::STEP_MS_CH3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_degree,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_pwm_one,
    output logic        o_pwm_two,
    output logic        o_pwm_three,
    output logic [2:0]  o_moving_mask,
    output logic [9:0]  o_position_one,
    output logic [9:0]  o_position_two,
    output logic [9:0]  o_position_three
);

    localparam int unsigned NCH = srv_pkg::NUM_CH;
    localparam int unsigned PB  = srv_pkg::PWM_BITS;

    // Configuration registers
    logic [7:0]  r_pulse_min [NCH];
    logic [7:0]  r_pulse_max [NCH];
    logic [15:0] r_ticks_per_ms;

    // Shared timing state
    logic [PB-1:0] r_pwm_count;
    logic [15:0]   r_ms_prescale;
    logic [PB-1:0] n_pwm_count;
    logic [15:0]   n_ms_prescale;

    // Result register
    logic            r_out_vld;
    logic [NCH-1:0]  r_pwm;
    logic [NCH-1:0]  r_moving;
    logic [PB-1:0]   r_pos [NCH];

    // Processing stage
    logic           in_vld;
    srv_pkg::t_item item;
    logic           fire;
    logic           is_set;
    logic           is_free;
    logic           is_tick;
    logic           wrap;
    logic           ms_tick;
    logic [16:0]    presc_inc;
    logic [31:0]    scaled;
    logic [7:0]     quot;
    logic [7:0]     tgt;

    srv_pkg::t_ch_ctl ch_ctl      [NCH];
    logic [PB-1:0]    cmp_next    [NCH];
    logic [PB-1:0]    act_next    [NCH];
    logic [NCH-1:0]   moving_next;
    logic [NCH-1:0]   pwm_next;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_pulse_min[c] <= srv_pkg::RST_PULSE_MIN;
                r_pulse_max[c] <= srv_pkg::RST_PULSE_MAX;
            end
            r_ticks_per_ms <= srv_pkg::RST_TICKS_PER_MS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                srv_pkg::CFG_CH1_MIN: r_pulse_min[0] <= i_cfg_data[7:0];
                srv_pkg::CFG_CH1_MAX: r_pulse_max[0] <= i_cfg_data[7:0];
                srv_pkg::CFG_CH2_MIN: r_pulse_min[1] <= i_cfg_data[7:0];
                srv_pkg::CFG_CH2_MAX: r_pulse_max[1] <= i_cfg_data[7:0];
                srv_pkg::CFG_CH3_MIN: r_pulse_min[2] <= i_cfg_data[7:0];
                srv_pkg::CFG_CH3_MAX: r_pulse_max[2] <= i_cfg_data[7:0];
                srv_pkg::CFG_TICKS:   r_ticks_per_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    srv_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_channel   (i_channel),
        .i_degree    (i_degree),
        .i_pulse_min (r_pulse_min),
        .i_pulse_max (r_pulse_max),
        .i_take      (fire),
        .o_vld       (in_vld),
        .o_item      (item)
    );

    // Process a word when the result register is free or being drained
    assign fire = in_vld && (!r_out_vld || !i_out_stall);

    // Decode the command
    always_comb begin
        is_set  = 1'b0;
        is_free = 1'b0;
        is_tick = 1'b0;
        unique case (item.cmd)
            srv_pkg::CMD_SET:  is_set  = fire;
            srv_pkg::CMD_FREE: is_free = fire;
            srv_pkg::CMD_TICK: is_tick = fire;
            default: ;
        endcase
    end

    // Scale the span product by 1/180 and add the minimum; inverted limits give the minimum
    always_comb begin
        scaled = 32'(item.prod) * srv_pkg::RECIP_180;
        quot   = scaled[srv_pkg::RECIP_SHIFT +: 8];
        tgt    = item.inv ? item.mn : (item.mn + quot);
    end

    // Advance the PWM counter and the millisecond prescaler
    always_comb begin
        presc_inc     = 17'(r_ms_prescale) + 17'd1;
        wrap          = is_tick && (r_pwm_count == srv_pkg::PWM_TOP);
        ms_tick       = is_tick && (presc_inc >= 17'(r_ticks_per_ms));
        n_pwm_count   = r_pwm_count;
        n_ms_prescale = r_ms_prescale;
        if (is_tick) begin
            n_pwm_count   = wrap ? '0 : (r_pwm_count + PB'(1));
            n_ms_prescale = ms_tick ? 16'd0 : presc_inc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_count   <= '0;
            r_ms_prescale <= 16'd0;
        end else begin
            r_pwm_count   <= n_pwm_count;
            r_ms_prescale <= n_ms_prescale;
        end
    end

    // Channels
    for (genvar g = 0; g < NCH; g++) begin : g_ch
        always_comb begin
            ch_ctl[g].set     = is_set  && (item.ch == 2'(g));
            ch_ctl[g].free    = is_free && (item.ch == 2'(g));
            ch_ctl[g].wrap    = wrap;
            ch_ctl[g].ms_tick = ms_tick;
            ch_ctl[g].tgt     = tgt;
        end

        srv_ramp_ch #(
            .STEP_MS ((g == 0) ? STEP_MS_CH1 : ((g == 1) ? STEP_MS_CH2 : STEP_MS_CH3))
        ) u_ch (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ch_ctl[g]),
            .o_cmp_next     (cmp_next[g]),
            .o_act_cmp_next (act_next[g]),
            .o_moving_next  (moving_next[g])
        );

        assign pwm_next[g] = (n_pwm_count <= act_next[g]);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pwm    <= pwm_next;
            r_moving <= moving_next;
            for (int c = 0; c < NCH; c++) begin
                r_pos[c] <= cmp_next[c];
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_pwm_one        = r_pwm[0];
    assign o_pwm_two        = r_pwm[1];
    assign o_pwm_three      = r_pwm[2];
    assign o_moving_mask    = r_moving;
    assign o_position_one   = r_pos[0];
    assign o_position_two   = r_pos[1];
    assign o_position_three = r_pos[2];

endmodule

>>> hdl/srv_chk.sv
// Port-level checks for the servo PWM block, attached by a bind statement.
// Depends only on the ports of servo_pwm_slew_ramp.
module srv_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_moving_mask,
    input logic [9:0] o_position_one,
    input logic [9:0] o_position_two,
    input logic [9:0] o_position_three
);

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_position_one)
            && $stable(o_position_two) && $stable(o_position_three)
            && $stable(o_moving_mask))
        else $error("stalled result word changed");

    // Drop the result valid after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A ramping channel always sits within the byte range
    a_ramp_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_moving_mask[0] || (o_position_one[9:8] == 2'b00))
            && (!o_moving_mask[1] || (o_position_two[9:8] == 2'b00))
            && (!o_moving_mask[2] || (o_position_three[9:8] == 2'b00)))
        else $error("ramping channel above byte range");

    // A freed first channel is never reported as moving
    a_free_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_position_one == 10'h3FF) |-> !o_moving_mask[0])
        else $error("freed channel reported as moving");

endmodule

bind servo_pwm_slew_ramp srv_chk u_srv_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_moving_mask    (o_moving_mask),
    .o_position_one   (o_position_one),
    .o_position_two   (o_position_two),
    .o_position_three (o_position_three)
);

>>> dv/tb_top.sv
// Self-checking testbench for servo_pwm_slew_ramp: directed and random command words,
// checked against a mirror of the PWM counter, ms prescaler and per-channel ramps.
// Depends on srv_pkg and the servo_pwm_slew_ramp RTL.
`timescale 1ns / 100ps

module tb_top;

    // Codes outside the defined set: they only report the current state (a tick ignores the channel)
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       pwm_one;
        logic       pwm_two;
        logic       pwm_three;
        logic [2:0] moving;
        logic [9:0] pos_one;
        logic [9:0] pos_two;
        logic [9:0] pos_three;
    } t_servo_status;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  command   = srv_pkg::CMD_TICK;
    logic [1:0]  channel   = '0;
    logic [7:0]  degree    = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        pwm_one;
    logic        pwm_two;
    logic        pwm_three;
    logic [2:0]  moving_mask;
    logic [9:0]  position_one;
    logic [9:0]  position_two;
    logic [9:0]  position_three;

    // Mirror of the block state and its registers
    logic [9:0]  m_count;
    logic [15:0] m_prescale;
    logic [15:0] m_ticks_per_ms;
    logic [7:0]  m_min [3];
    logic [7:0]  m_max [3];
    logic [7:0]  m_target [3];
    logic [7:0]  m_wait [3];
    logic [9:0]  m_pos [3];
    logic [9:0]  m_active [3];
    logic        m_moving [3];

    t_servo_status pending_status[$];
    int unsigned   mismatch_count = 0;
    int unsigned   word_count     = 0;
    int unsigned   cycle_count    = 0;
    bit            idling         = 1'b0;
    int unsigned   stall_left     = 0;

    servo_pwm_slew_ramp u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_command        (command),
        .i_channel        (channel),
        .i_degree         (degree),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_pwm_one        (pwm_one),
        .o_pwm_two        (pwm_two),
        .o_pwm_three      (pwm_three),
        .o_moving_mask    (moving_mask),
        .o_position_one   (position_one),
        .o_position_two   (position_two),
        .o_position_three (position_three)
    );

    always #1 i_clk = ~i_clk;

    // Step delay in ms for one channel; a zero delay acts as one
    function automatic logic [7:0] step_delay(int c);
        int unsigned d;
        case (c)
            0: d = srv_pkg::STEP_MS_CH1;
            1: d = srv_pkg::STEP_MS_CH2;
            default: d = srv_pkg::STEP_MS_CH3;
        endcase
        d = d & 32'hFF;
        return (d == 0) ? 8'd1 : 8'(d);
    endfunction

    // Move one channel a step toward its target, from the low byte of its position
    function automatic void step_toward(int c);
        logic [7:0] cur;
        cur = m_pos[c][7:0];
        if (cur < m_target[c]) begin
            cur = cur + 1'b1;
        end else if (cur > m_target[c]) begin
            cur = cur - 1'b1;
        end
        m_pos[c]    = {2'b00, cur};
        m_moving[c] = (cur != m_target[c]);
        m_wait[c]   = m_moving[c] ? step_delay(c) : 8'd0;
    endfunction

    function automatic void reset_mirror();
        for (int c = 0; c < 3; c++) begin
            m_min[c]    = srv_pkg::RST_PULSE_MIN;
            m_max[c]    = srv_pkg::RST_PULSE_MAX;
            m_target[c] = srv_pkg::RESET_POS;
            m_pos[c]    = {2'b00, srv_pkg::RESET_POS};
            m_active[c] = {2'b00, srv_pkg::RESET_POS};
            m_wait[c]   = '0;
            m_moving[c] = 1'b0;
        end
        m_ticks_per_ms = srv_pkg::RST_TICKS_PER_MS;
        m_count        = '0;
        m_prescale     = '0;
    endfunction

    // Apply one command word to the mirror and return the status it produces
    function automatic t_servo_status advance_servo(logic [1:0] cmd, logic [1:0] ch,
                                                    logic [7:0] deg);
        int unsigned   span;
        int unsigned   angle;
        t_servo_status st;
        if (cmd == srv_pkg::CMD_SET && ch != CH_NONE) begin
            angle = (deg > srv_pkg::MAX_DEG) ? srv_pkg::MAX_DEG : deg;
            if (m_max[ch] < m_min[ch]) begin
                m_target[ch] = m_min[ch];
            end else begin
                span         = m_max[ch] - m_min[ch];
                m_target[ch] = 8'(m_min[ch] + span * angle / srv_pkg::MAX_DEG);
            end
            step_toward(ch);
        end else if (cmd == srv_pkg::CMD_FREE && ch != CH_NONE) begin
            m_pos[ch]    = srv_pkg::PWM_TOP;
            m_moving[ch] = 1'b0;
            m_wait[ch]   = '0;
        end else if (cmd == srv_pkg::CMD_TICK) begin
            // Counter first: on wrap, load the active compares from the old positions
            if (m_count == srv_pkg::PWM_TOP) begin
                m_count = '0;
                for (int c = 0; c < 3; c++) m_active[c] = m_pos[c];
            end else begin
                m_count = m_count + 1'b1;
            end
            // Then the shared ms prescaler and the ramps
            if (int'(m_prescale) + 1 >= int'(m_ticks_per_ms)) begin
                m_prescale = '0;
                for (int c = 0; c < 3; c++) begin
                    if (m_moving[c]) begin
                        if (m_wait[c] > 1) m_wait[c] = m_wait[c] - 1'b1;
                        else step_toward(c);
                    end
                end
            end else begin
                m_prescale = m_prescale + 1'b1;
            end
        end
        st.pwm_one   = (m_count <= m_active[0]);
        st.pwm_two   = (m_count <= m_active[1]);
        st.pwm_three = (m_count <= m_active[2]);
        st.moving    = {m_moving[2], m_moving[1], m_moving[0]};
        st.pos_one   = m_pos[0];
        st.pos_two   = m_pos[1];
        st.pos_three = m_pos[2];
        return st;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("%0t: word %0d %s: got %0d, want %0d", $time, word_count, what, got, want);
    endtask

    // Register write; the block must be idle
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == srv_pkg::CFG_TICKS) begin
            m_ticks_per_ms = value;
        end else if (idx <= srv_pkg::CFG_CH3_MAX) begin
            if (idx[0]) m_max[idx >> 1] = value[7:0];
            else m_min[idx >> 1] = value[7:0];
        end
    endtask

    task automatic program_channel(int c, logic [7:0] lo, logic [7:0] hi);
        write_reg(3'(srv_pkg::CFG_CH1_MIN + 2 * c), {8'd0, lo});
        write_reg(3'(srv_pkg::CFG_CH1_MAX + 2 * c), {8'd0, hi});
    endtask

    // Send one word and record what it should produce; called at a rising edge
    task automatic send_word(logic [1:0] cmd, logic [1:0] ch, logic [7:0] deg);
        int unsigned gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        channel  <= ch;
        degree   <= deg;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        pending_status.push_back(advance_servo(cmd, ch, deg));
    endtask

    // Hold off input until every pending word has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly ticks to keep ramps and counter moving, with sets, frees and noise
    task automatic send_random_word();
        int unsigned pick;
        logic [1:0]  ch;
        logic [7:0]  deg;
        pick = $urandom_range(0, 99);
        ch   = 2'($urandom_range(0, 2));
        deg  = 8'($urandom_range(0, 180));
        if (pick < 78) send_word(srv_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
        else if (pick < 92) send_word(srv_pkg::CMD_SET, ch, deg);
        else if (pick < 95) send_word(srv_pkg::CMD_FREE, ch, 8'($urandom));
        else send_word(2'($urandom), 2'($urandom), 8'($urandom));
    endtask

    task automatic randomize_limits(logic [15:0] ticks);
        for (int c = 0; c < 3; c++)
            program_channel(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        write_reg(srv_pkg::CFG_TICKS, ticks);
    endtask

    // A tick, then undefined command and channel codes right after reset
    task automatic test_reset_state();
        send_word(srv_pkg::CMD_TICK, 2'd0, 8'd0);
        send_word(CMD_NOP, CH_NONE, 8'hFF);
        send_word(srv_pkg::CMD_SET, CH_NONE, 8'd90);
        send_word(srv_pkg::CMD_FREE, CH_NONE, 8'd0);
    endtask

    // Angle extremes, saturation, free and retarget from a freed channel
    task automatic test_directed_corners();
        send_word(srv_pkg::CMD_SET, 2'd0, 8'd0);
        send_word(srv_pkg::CMD_SET, 2'd1, 8'd180);
        send_word(srv_pkg::CMD_SET, 2'd2, 8'd255);
        send_word(srv_pkg::CMD_TICK, 2'd3, 8'hAA);
        send_word(srv_pkg::CMD_FREE, 2'd0, 8'd0);
        send_word(srv_pkg::CMD_SET, 2'd0, 8'd90);
        send_word(srv_pkg::CMD_SET, 2'd1, 8'd181);
        send_word(srv_pkg::CMD_FREE, 2'd2, 8'd0);
        send_word(srv_pkg::CMD_TICK, 2'd1, 8'h55);
        send_word(srv_pkg::CMD_SET, 2'd2, 8'd1);
        send_word(srv_pkg::CMD_SET, 2'd1, 8'd0);
        send_word(CMD_NOP, 2'd0, 8'd180);
        send_word(srv_pkg::CMD_FREE, 2'd1, 8'hFF);
        send_word(srv_pkg::CMD_TICK, 2'd0, 8'd0);
    endtask

    // Full-span, inverted and pinned limits at one tick per ms
    task automatic test_limit_extremes();
        settle();
        program_channel(0, 8'd0, 8'd255);
        program_channel(1, 8'd200, 8'd10);
        program_channel(2, 8'd255, 8'd255);
        write_reg(srv_pkg::CFG_TICKS, 16'd1);
        send_word(srv_pkg::CMD_SET, 2'd0, 8'd180);
        send_word(srv_pkg::CMD_SET, 2'd1, 8'd90);
        send_word(srv_pkg::CMD_FREE, 2'd2, 8'd0);
        // freed position has low byte 255, equal to the pinned target: no ramp
        send_word(srv_pkg::CMD_SET, 2'd2, 8'd45);
        send_word(srv_pkg::CMD_SET, 2'd0, 8'd0);
        repeat (40) send_word(srv_pkg::CMD_TICK, 2'($urandom), 8'($urandom));
    endtask

    // Random traffic with idling on both sides, a new register setting per phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            randomize_limits(16'($urandom_range(1, 4)));
            idling <= 1'b1;
            repeat (180) send_random_word();
        end
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_drain_pauses();
        idling <= 1'b1;
        repeat (4) begin
            repeat (25) send_random_word();
            settle();
        end
    endtask

    // Back-to-back words, slowest and fastest prescaler
    task automatic test_steady_no_idle();
        settle();
        idling <= 1'b0;
        write_reg(srv_pkg::CFG_TICKS, 16'hFFFF);
        repeat (60) send_random_word();
        settle();
        program_channel(2, 8'd0, 8'd255);
        write_reg(srv_pkg::CFG_TICKS, 16'd1);
        repeat (90) send_random_word();
    endtask

    // Output stall in random bursts while idling
    always @(posedge i_clk) begin
        if (!idling) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result word with the oldest pending status
    always @(posedge i_clk) begin : check_word
        t_servo_status want;
        if (i_rst_n && out_valid && !out_stall) begin
            word_count++;
            if (pending_status.size() == 0) begin
                flag_mismatch("word with nothing pending", 1, 0);
            end else begin
                want = pending_status.pop_front();
                if (pwm_one !== want.pwm_one)
                    flag_mismatch("pwm_one", pwm_one, want.pwm_one);
                if (pwm_two !== want.pwm_two)
                    flag_mismatch("pwm_two", pwm_two, want.pwm_two);
                if (pwm_three !== want.pwm_three)
                    flag_mismatch("pwm_three", pwm_three, want.pwm_three);
                if (moving_mask !== want.moving)
                    flag_mismatch("moving_mask", moving_mask, want.moving);
                if (position_one !== want.pos_one)
                    flag_mismatch("position_one", position_one, want.pos_one);
                if (position_two !== want.pos_two)
                    flag_mismatch("position_two", position_two, want.pos_two);
                if (position_three !== want.pos_three)
                    flag_mismatch("position_three", position_three, want.pos_three);
            end
        end
    end

    // Abort a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("servo_pwm_slew_ramp regression: fail");
        $finish;
    end

    initial begin
        reset_mirror();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_corners();
        test_limit_extremes();
        test_random_traffic();
        test_drain_pauses();
        test_steady_no_idle();
        settle();
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("servo_pwm_slew_ramp regression: pass");
        end else begin
            $display("servo_pwm_slew_ramp regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/srv_pkg.sv
hdl/srv_in_stage.sv
hdl/srv_ramp_ch.sv
hdl/servo_pwm_slew_ramp.sv
hdl/srv_chk.sv
dv/tb_top.sv
